// ----- rtl/circular_deque_defines.svh -----
// ----------------------------------------------------------------------------
// Circular deque assertion macros
// Shared property templates for the concurrent checks of the deque.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("circular_deque: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> cons) \
    else $error("circular_deque: next-cycle check failed");

`endif

// ----- rtl/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// Circular deque package
// Operation and status codes, beat types and controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [2:0] FUNC_PEEK_FRONT = 3'd4;
  localparam logic [2:0] FUNC_PEEK_BACK  = 3'd5;
  localparam logic [2:0] FUNC_SIZE       = 3'd6;
  localparam logic [2:0] FUNC_EMPTY      = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic [7:0]         count;
    logic               is_empty;
  } out_beat_t;

  typedef struct packed {
    logic exec;
    logic load;
  } cdq_cmd_t;

endpackage

// ----- rtl/circular_deque.sv -----
// ----------------------------------------------------------------------------
// Circular deque
// Double-ended queue of signed words held in a wrapping store.
// ----------------------------------------------------------------------------
// Each input beat is one operation and yields exactly one output beat. In
// the cycle an operation is accepted the pointers and occupancy are updated
// and the store is written or read, and in the next cycle the registered
// read data is formed into the result register. A new beat is accepted in
// the cycle after that, while the previous result is still offered,
// provided that result is taken in the same cycle or has already gone;
// because of the registered read port of the store, no beat is accepted
// while the previous one is still being formed into its result. There is no
// clearing pass after reset; only data of occupied entries is ever returned.
`timescale 1ns / 1ps

`include "circular_deque_defines.svh"

module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  cdq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  `CDQ_ASSERT_NEXT(a_accept_to_result, clk_i, rst_ni, cmd.exec, ##1 out_valid_o)
  `CDQ_ASSERT_IMPL(a_exec_load_apart, clk_i, rst_ni, cmd.load, !cmd.exec)
  `CDQ_ASSERT_IMPL(a_overflow_data, clk_i, rst_ni, out_valid_o && (out_data_o.status == ST_OVERFLOW), out_data_o.data == 32'sd0)
  `CDQ_ASSERT_IMPL(a_empty_result, clk_i, rst_ni, out_valid_o && (out_data_o.status == ST_EMPTY), out_data_o.is_empty && (out_data_o.data == -32'sd1))

endmodule

// ----- rtl/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences each operation and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cdq_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_stall_o = (state_q == S_EXEC) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.exec = accept;
  assign cmd_o.load = (state_q == S_EXEC);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/cdq_dp.sv -----
// ----------------------------------------------------------------------------
// Circular deque datapath
// Word store, wrapping front and back pointers, occupancy and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdq_dp
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cdq_cmd_t  cmd_i,
  input  in_beat_t  in_data_i,
  output out_beat_t out_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [OW-1:0] FULL = OW'(DEPTH);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? LAST : p - PW'(1);
  endfunction

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;

  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [OW-1:0] occ_q, occ_d;
  logic [2:0]    func_q;
  logic [1:0]    status_q, status_d;
  out_beat_t     out_q;

  logic          front, is_full, is_empty, we;
  logic [PW-1:0] waddr, raddr;
  logic signed [DATA_WIDTH-1:0] rd_s;

  assign front    = in_data_i.func inside {FUNC_PUSH_FRONT, FUNC_POP_FRONT, FUNC_PEEK_FRONT};
  assign is_full  = (occ_q == FULL);
  assign is_empty = (occ_q == '0);
  assign raddr    = front ? head_q : tail_q;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    status_d = ST_OK;
    we       = 1'b0;
    waddr    = head_q;
    case (in_data_i.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (is_full) begin
          status_d = ST_OVERFLOW;
        end else begin
          if (is_empty) begin
            head_d = '0;
            tail_d = '0;
          end else if (front) begin
            head_d = ptr_dec(head_q);
          end else begin
            tail_d = ptr_inc(tail_q);
          end
          waddr = front ? head_d : tail_d;
          we    = 1'b1;
          occ_d = occ_q + OW'(1);
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          occ_d = occ_q - OW'(1);
          if (occ_q == OW'(1)) begin
            head_d = '0;
            tail_d = '0;
          end else if (front) begin
            head_d = ptr_inc(head_q);
          end else begin
            tail_d = ptr_dec(tail_q);
          end
        end
      end
      FUNC_PEEK_FRONT, FUNC_PEEK_BACK: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (we) begin
        mem_q[waddr] <= DATA_WIDTH'($unsigned(in_data_i.value));
      end
      rd_q     <= mem_q[raddr];
      func_q   <= in_data_i.func;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
    end
  end

  assign rd_s = $signed(rd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.status   <= status_q;
      out_q.count    <= 8'(occ_q);
      out_q.is_empty <= (occ_q == '0);
      if (status_q == ST_EMPTY) begin
        out_q.data <= '1;
      end else if (func_q inside {[FUNC_POP_FRONT:FUNC_PEEK_BACK]}) begin
        out_q.data <= 32'(rd_s);
      end else if (func_q == FUNC_SIZE) begin
        out_q.data <= 32'(occ_q);
      end else begin
        out_q.data <= '0;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Circular deque testbench
// Drives operation beats into the deque with random gaps and random output
// stalls, takes each expected result from the directed table or from its own
// copy of the deque state and compares each result beat field by field. A
// short directed table covers the empty and extreme cases, then phases of
// random operations fill to overflow, drain past empty and mix in between.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cdq_pkg::*;

  localparam int RAND_OPS    = 1150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 10;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] word;
    logic        fixed;
    out_beat_t   want;
  } dir_row_t;

  localparam out_beat_t R_NONE      = '0;
  localparam out_beat_t R_EMPTY_ERR = '{32'hFFFF_FFFF, ST_EMPTY, 8'd0, 1'b1};
  localparam out_beat_t R_IDLE      = '{32'h0, ST_OK, 8'd0, 1'b1};
  localparam out_beat_t R_PUSH_ONE  = '{32'h0, ST_OK, 8'd1, 1'b0};
  localparam out_beat_t R_PUSH_TWO  = '{32'h0, ST_OK, 8'd2, 1'b0};
  localparam out_beat_t R_MIN_HELD  = '{32'h8000_0000, ST_OK, 8'd1, 1'b0};
  localparam out_beat_t R_MIN_LAST  = '{32'h8000_0000, ST_OK, 8'd0, 1'b1};

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    '{FUNC_POP_FRONT,  32'h0,         1'b1, R_EMPTY_ERR},
    '{FUNC_POP_BACK,   32'h1234_5678, 1'b1, R_EMPTY_ERR},
    '{FUNC_PEEK_FRONT, 32'h0,         1'b1, R_EMPTY_ERR},
    '{FUNC_PEEK_BACK,  32'hFFFF_FFFF, 1'b1, R_EMPTY_ERR},
    '{FUNC_SIZE,       32'h0,         1'b1, R_IDLE},
    '{FUNC_EMPTY,      32'h0,         1'b1, R_IDLE},
    '{FUNC_PUSH_FRONT, 32'h8000_0000, 1'b1, R_PUSH_ONE},
    '{FUNC_PEEK_FRONT, 32'h0,         1'b1, R_MIN_HELD},
    '{FUNC_PEEK_BACK,  32'h0,         1'b1, R_MIN_HELD},
    '{FUNC_POP_BACK,   32'h0,         1'b1, R_MIN_LAST},
    '{FUNC_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, R_PUSH_ONE},
    '{FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, R_PUSH_TWO},
    '{FUNC_PUSH_FRONT, 32'h0,         1'b0, R_NONE},
    '{FUNC_PUSH_BACK,  32'h5555_5555, 1'b0, R_NONE},
    '{FUNC_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, R_NONE},
    '{FUNC_SIZE,       32'hFFFF_FFFF, 1'b0, R_NONE},
    '{FUNC_EMPTY,      32'hFFFF_FFFF, 1'b0, R_NONE},
    '{FUNC_PEEK_FRONT, 32'h0,         1'b0, R_NONE},
    '{FUNC_POP_FRONT,  32'h0,         1'b0, R_NONE},
    '{FUNC_POP_BACK,   32'h0,         1'b0, R_NONE},
    '{FUNC_POP_FRONT,  32'h0,         1'b0, R_NONE},
    '{FUNC_POP_BACK,   32'h0,         1'b0, R_NONE},
    '{FUNC_POP_FRONT,  32'h0,         1'b0, R_NONE},
    '{FUNC_POP_BACK,   32'h0,         1'b1, R_EMPTY_ERR},
    '{FUNC_EMPTY,      32'h0,         1'b1, R_IDLE}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  logic signed [31:0] dq_mem [0:DEPTH_DEF-1];
  logic [6:0]         dq_head;
  logic [6:0]         dq_tail;
  logic [7:0]         dq_occ;

  out_beat_t pending_results [$];
  out_beat_t got_want;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        sink_wait = 0;
  int        rand_sent = 0;
  bit        src_idle = 1'b1;
  bit        sink_idle = 1'b1;

  circular_deque DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic deque_apply(input in_beat_t op_beat, output out_beat_t res);
    logic front;
    res = '0;
    res.status = ST_OK;
    front = (op_beat.func == FUNC_PUSH_FRONT) || (op_beat.func == FUNC_POP_FRONT) ||
            (op_beat.func == FUNC_PEEK_FRONT);
    case (op_beat.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (int'(dq_occ) >= DEPTH_DEF) begin
          res.status = ST_OVERFLOW;
        end else begin
          if (dq_occ == 8'd0) begin
            dq_head = '0;
            dq_tail = '0;
          end else if (front) begin
            dq_head = dq_head - 7'd1;
          end else begin
            dq_tail = dq_tail + 7'd1;
          end
          dq_mem[front ? dq_head : dq_tail] = op_beat.value;
          dq_occ++;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_PEEK_FRONT, FUNC_PEEK_BACK: begin
        if (dq_occ == 8'd0) begin
          res.data   = -32'sd1;
          res.status = ST_EMPTY;
        end else begin
          res.data = dq_mem[front ? dq_head : dq_tail];
          if (op_beat.func == FUNC_POP_FRONT || op_beat.func == FUNC_POP_BACK) begin
            dq_occ--;
            if (dq_occ == 8'd0) begin
              dq_head = '0;
              dq_tail = '0;
            end else if (front) begin
              dq_head = dq_head + 7'd1;
            end else begin
              dq_tail = dq_tail - 7'd1;
            end
          end
        end
      end
      FUNC_SIZE: begin
        res.data = {24'd0, dq_occ};
      end
      default: begin
      end
    endcase
    res.count    = dq_occ;
    res.is_empty = (dq_occ == 8'd0);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time,
                 out_data_o);
        fail_count++;
      end else begin
        got_want = pending_results[0];
        pending_results.delete(0);
        check_field("data", got_want.data, out_data_o.data);
        check_field("status", 32'(got_want.status), 32'(out_data_o.status));
        check_field("count", 32'(got_want.count), 32'(out_data_o.count));
        check_field("is_empty", 32'(got_want.is_empty), 32'(out_data_o.is_empty));
      end
      sink_wait = sink_idle ? $urandom_range(0, 6) : 0;
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    out_stall_i <= (sink_wait > 0);
  end

  task automatic send_op(input in_beat_t op_beat, input logic fixed,
                         input out_beat_t want);
    int        gap;
    out_beat_t pred;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op_beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    deque_apply(op_beat, pred);
    pending_results.insert(pending_results.size(), fixed ? want : pred);
  endtask

  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] draw_op(int push_pct, int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
    if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
    case ($urandom_range(0, 3))
      0:       return FUNC_PEEK_FRONT;
      1:       return FUNC_PEEK_BACK;
      2:       return FUNC_SIZE;
      default: return FUNC_EMPTY;
    endcase
  endfunction

  task automatic send_random(input int push_pct, input int pop_pct);
    in_beat_t b;
    b.func  = draw_op(push_pct, pop_pct);
    b.value = draw_word();
    send_op(b, 1'b0, R_NONE);
    rand_sent++;
  endtask

  task automatic wait_all_results();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    in_beat_t b;
    int       len;
    int       push_pct;
    int       pop_pct;
    dq_head = '0;
    dq_tail = '0;
    dq_occ  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      b.func  = DIR_TAB[i].op;
      b.value = DIR_TAB[i].word;
      send_op(b, DIR_TAB[i].fixed, DIR_TAB[i].want);
    end
    in_valid_i <= 1'b0;
    wait_all_results();

    // Fill to the brim and keep pushing at both ends so that overflow is hit.
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    while (int'(dq_occ) < DEPTH_DEF) send_random(100, 0);
    repeat (6) send_random(100, 0);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (20) send_random(30, 30);
    while (dq_occ != 8'd0) send_random(0, 100);
    repeat (6) send_random(0, 50);

    while (rand_sent < RAND_OPS) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       begin push_pct = 70; pop_pct = 20; end
        1:       begin push_pct = 20; pop_pct = 70; end
        2:       begin push_pct = 40; pop_pct = 40; end
        default: begin push_pct = 85; pop_pct = 10; end
      endcase
      len = $urandom_range(60, 160);
      if (len > RAND_OPS - rand_sent) len = RAND_OPS - rand_sent;
      repeat (len) send_random(push_pct, pop_pct);
      if ($urandom_range(0, 2) == 0) begin
        in_valid_i <= 1'b0;
        wait_all_results();
      end
    end

    in_valid_i <= 1'b0;
    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_dp.sv
rtl/circular_deque.sv
bench/tb_top.sv
